FILE: src/rlebr_pkg.sv
package rlebr_pkg;

    localparam int ADDR_BITS_DEF = 12;
    localparam int ADDRESS_W     = 12;
    localparam int DATA_W        = 8;
    localparam int LEFT_W        = 8;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_FETCH  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] KIND_LIT0   = 3'd0;
    localparam logic [2:0] KIND_LIT1   = 3'd1;
    localparam logic [2:0] KIND_REPEAT = 3'd2;
    localparam logic [2:0] KIND_PAT4   = 3'd3;
    localparam logic [2:0] KIND_PAT2   = 3'd4;
    localparam logic [2:0] KIND_PAT3   = 3'd5;
    localparam logic [2:0] KIND_REF0   = 3'd6;
    localparam logic [2:0] KIND_REF1   = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic wr;         // store write
        logic set_start;  // load stream start, clear run state
        logic rd_cont;    // read next byte of the active run
        logic rd_tag;     // read tag at main position
        logic decode;     // tag in read data: set up run, read first operand
        logic rd_offlo;   // offset high byte in read data, read low byte
        logic backref;    // offset complete: read first copied byte or end
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ended;
        logic left_zero;
        logic ref_kind;   // tag in read data is a back-reference
    } t_sts;

endpackage

FILE: src/rlebr_ctrl.sv
module rlebr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic [1:0]            i_opcode,
    input  rlebr_pkg::t_sts       i_sts,
    output rlebr_pkg::t_cmd       o_cmd,
    output logic                  busy,
    output logic                  o_strobe
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_OFFH   = 5'b00100,
        ST_OFFL   = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = (r_state == ST_EMIT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    unique case (i_opcode)
                        rlebr_pkg::OP_WRITE: begin
                            o_cmd.wr = 1'b1;
                        end
                        rlebr_pkg::OP_START: begin
                            o_cmd.set_start = 1'b1;
                        end
                        rlebr_pkg::OP_FETCH: begin
                            if (i_sts.ended) begin
                                n_state = ST_EMIT;
                            end else if (i_sts.left_zero) begin
                                o_cmd.rd_tag = 1'b1;
                                n_state      = ST_DECODE;
                            end else begin
                                o_cmd.rd_cont = 1'b1;
                                n_state       = ST_EMIT;
                            end
                        end
                        rlebr_pkg::OP_UNUSED: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_sts.ref_kind ? ST_OFFH : ST_EMIT;
            end
            ST_OFFH: begin
                o_cmd.rd_offlo = 1'b1;
                n_state        = ST_OFFL;
            end
            ST_OFFL: begin
                o_cmd.backref = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/rlebr_dpath.sv
module rlebr_dpath #(
    parameter int ADDR_BITS = rlebr_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rlebr_pkg::t_cmd                   i_cmd,
    input  logic [rlebr_pkg::ADDRESS_W-1:0]   i_address,
    input  logic [rlebr_pkg::DATA_W-1:0]      i_data,
    output rlebr_pkg::t_sts                   o_sts,
    output logic [rlebr_pkg::DATA_W-1:0]      o_out_byte,
    output logic                              o_stream_end
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [rlebr_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [rlebr_pkg::DATA_W-1:0] r_rdata;

    logic [ADDR_BITS-1:0]         r_main, n_main;
    logic [ADDR_BITS-1:0]         r_read, n_read;
    logic [rlebr_pkg::LEFT_W-1:0] r_left, n_left;
    logic [2:0]                   r_kind, n_kind;
    logic                         r_ended, n_ended;
    logic [rlebr_pkg::DATA_W-1:0] r_tag, r_off_hi;

    logic [ADDR_BITS-1:0]         w_wr_addr;
    logic [ADDR_BITS-1:0]         w_rd_addr;
    logic                         w_rd_en;
    logic [ADDR_BITS-1:0]         w_cont_addr;
    logic [ADDR_BITS-1:0]         w_ref_addr;
    logic [2:0]                   w_kind;
    logic [15:0]                  w_off;
    logic [5:0]                   w_reps;
    logic                         w_is_pat;

    function automatic logic [2:0] pat_len(input logic [2:0] kind);
        logic [2:0] len;
        if (kind == rlebr_pkg::KIND_PAT4) begin
            len = 3'd4;
        end else if (kind == rlebr_pkg::KIND_PAT2) begin
            len = 3'd2;
        end else begin
            len = 3'd3;
        end
        return len;
    endfunction

    assign w_wr_addr  = ADDR_BITS'(i_address);
    assign w_kind     = r_rdata[7:5];
    assign w_off      = {r_off_hi, r_rdata};
    assign w_ref_addr = r_main + ADDR_BITS'(w_off);
    assign w_reps     = {1'b0, r_rdata[4:0]} + 6'd2;
    assign w_is_pat   = (r_kind == rlebr_pkg::KIND_PAT4) || (r_kind == rlebr_pkg::KIND_PAT2)
                     || (r_kind == rlebr_pkg::KIND_PAT3);

    // pattern runs wrap back over the pattern once the reader catches up
    always_comb begin
        w_cont_addr = r_read;
        if (w_is_pat && (r_read == r_main)) begin
            w_cont_addr = r_read - ADDR_BITS'(pat_len(r_kind));
        end
    end

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_main;
        priority if (i_cmd.rd_tag || i_cmd.decode) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_main;
        end else if (i_cmd.rd_cont) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_cont_addr;
        end else if (i_cmd.rd_offlo) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_main + ADDR_BITS'(1);
        end else if (i_cmd.backref) begin
            w_rd_en   = 1'b1;
            w_rd_addr = w_ref_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[w_wr_addr] <= i_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
        if (i_cmd.decode) begin
            r_tag <= r_rdata;
        end
        if (i_cmd.rd_offlo) begin
            r_off_hi <= r_rdata;
        end
    end

    always_comb begin
        n_main  = r_main;
        n_read  = r_read;
        n_left  = r_left;
        n_kind  = r_kind;
        n_ended = r_ended;
        priority if (i_cmd.set_start) begin
            n_main  = w_wr_addr;
            n_read  = w_wr_addr;
            n_left  = '0;
            n_kind  = rlebr_pkg::KIND_LIT0;
            n_ended = 1'b0;
        end else if (i_cmd.rd_tag) begin
            n_main = r_main + ADDR_BITS'(1);
        end else if (i_cmd.rd_cont) begin
            n_left = r_left - 8'd1;
            if (r_kind != rlebr_pkg::KIND_REPEAT) begin
                n_read = w_cont_addr + ADDR_BITS'(1);
            end
        end else if (i_cmd.decode) begin
            // r_main already points past the tag
            n_kind = w_kind;
            n_read = r_main + ADDR_BITS'(1);
            unique case (w_kind)
                rlebr_pkg::KIND_LIT0, rlebr_pkg::KIND_LIT1: begin
                    n_left = {2'b00, r_rdata[5:0]};
                    n_main = r_main + ADDR_BITS'(r_rdata[5:0]) + ADDR_BITS'(1);
                end
                rlebr_pkg::KIND_REPEAT: begin
                    n_read = r_main;
                    n_main = r_main + ADDR_BITS'(1);
                    n_left = {3'b000, r_rdata[4:0]} + 8'd2;
                end
                rlebr_pkg::KIND_PAT4: begin
                    n_main = r_main + ADDR_BITS'(4);
                    n_left = {w_reps, 2'b00} - 8'd1;
                end
                rlebr_pkg::KIND_PAT2: begin
                    n_main = r_main + ADDR_BITS'(2);
                    n_left = {1'b0, w_reps, 1'b0} - 8'd1;
                end
                rlebr_pkg::KIND_PAT3: begin
                    n_main = r_main + ADDR_BITS'(3);
                    n_left = {1'b0, w_reps, 1'b0} + {2'b00, w_reps} - 8'd1;
                end
                rlebr_pkg::KIND_REF0, rlebr_pkg::KIND_REF1: begin
                    n_main = r_main;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.backref) begin
            if (w_off == 16'd0) begin
                n_ended = 1'b1;
                n_left  = '0;
            end else begin
                n_read = w_ref_addr + ADDR_BITS'(1);
                n_main = r_main + ADDR_BITS'(2);
                n_left = {2'b00, r_tag[5:0]} + 8'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main  <= '0;
            r_read  <= '0;
            r_left  <= '0;
            r_kind  <= rlebr_pkg::KIND_LIT0;
            r_ended <= 1'b0;
        end else begin
            r_main  <= n_main;
            r_read  <= n_read;
            r_left  <= n_left;
            r_kind  <= n_kind;
            r_ended <= n_ended;
        end
    end

    assign o_sts.ended     = r_ended;
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.ref_kind  = (w_kind == rlebr_pkg::KIND_REF0) || (w_kind == rlebr_pkg::KIND_REF1);

    assign o_out_byte   = r_ended ? '0 : r_rdata;
    assign o_stream_end = r_ended;

endmodule

FILE: src/rle_backref_byte_decompressor.sv
// Channel   Direction  Ports                             Handshake
// request   in         i_opcode, i_address, i_data       start high, busy low
// result    out        o_out_byte, o_stream_end          o_strobe, one cycle, no stall
//
// Write, start and unused requests never leave idle. A fetch passes through emit alone
// when the stream has ended or a run is active, through decode and emit when it opens a
// literal, repeat or pattern run, and through decode, offset high, offset low and emit
// for a back-reference. The result shows on the cycle before busy drops.
// Synchronous active-low reset clears the pointers and run state; the store keeps its
// contents and needs no clearing. The receiver cannot stall the result.
module rle_backref_byte_decompressor #(
    parameter int ADDR_BITS = rlebr_pkg::ADDR_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_opcode,
    input  logic [rlebr_pkg::ADDRESS_W-1:0]   i_address,
    input  logic [rlebr_pkg::DATA_W-1:0]      i_data,
    output logic                              o_strobe,
    output logic [rlebr_pkg::DATA_W-1:0]      o_out_byte,
    output logic                              o_stream_end
);

    rlebr_pkg::t_cmd w_cmd;
    rlebr_pkg::t_sts w_sts;

    rlebr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    rlebr_dpath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_address    (i_address),
        .i_data       (i_data),
        .o_sts        (w_sts),
        .o_out_byte   (o_out_byte),
        .o_stream_end (o_stream_end)
    );

endmodule

FILE: sim/rlebr_checker.sv
module rlebr_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [1:0]                       i_opcode,
    input  logic [rlebr_pkg::ADDRESS_W-1:0]  i_address,
    input  logic [rlebr_pkg::DATA_W-1:0]     i_data,
    input  logic                             i_strobe,
    input  logic [rlebr_pkg::DATA_W-1:0]     i_out_byte,
    input  logic                             i_stream_end,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_end_seen
);
    import rlebr_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              at_end;
    } t_fetch_result;

    logic [DATA_W-1:0]    comp_mem [0:(1<<ADDRESS_W)-1];
    logic [ADDRESS_W-1:0] parse_pos;
    logic [ADDRESS_W-1:0] copy_pos;
    logic [LEFT_W-1:0]    run_left;
    logic [2:0]           run_kind;
    logic                 stream_done;
    t_fetch_result        expected_bytes [$];
    t_fetch_result        want;

    function automatic logic [ADDRESS_W-1:0] pattern_span(input logic [2:0] k);
        case (k)
            KIND_PAT4: return ADDRESS_W'(4);
            KIND_PAT2: return ADDRESS_W'(2);
            default:   return ADDRESS_W'(3);
        endcase
    endfunction

    // one decompressed byte per fetch; updates the parse state
    function automatic t_fetch_result decode_fetch();
        t_fetch_result        res;
        logic [DATA_W-1:0]    tag;
        logic [15:0]          offset;
        logic [ADDRESS_W-1:0] plen;
        res = '0;
        if (stream_done) begin
            res.at_end = 1'b1;
            return res;
        end
        if (run_left != 0) begin
            run_left = run_left - 1'b1;
            if (run_kind == KIND_REPEAT) begin
                res.value = comp_mem[copy_pos];
            end else begin
                // pattern runs loop back over the pattern bytes
                if (run_kind >= KIND_PAT4 && run_kind <= KIND_PAT3 && copy_pos == parse_pos)
                    copy_pos = copy_pos - pattern_span(run_kind);
                res.value = comp_mem[copy_pos];
                copy_pos = copy_pos + 1'b1;
            end
            return res;
        end
        tag = comp_mem[parse_pos];
        run_kind = tag[7:5];
        parse_pos = parse_pos + 1'b1;
        copy_pos = parse_pos;
        case (run_kind)
            KIND_LIT0, KIND_LIT1: begin
                run_left = {2'b00, tag[5:0]};
                parse_pos = parse_pos + run_left + 1'b1;
            end
            KIND_REPEAT: begin
                parse_pos = parse_pos + 1'b1;
                run_left = tag[4:0] + 8'd2;
                res.value = comp_mem[copy_pos];
                return res;
            end
            KIND_PAT4, KIND_PAT2, KIND_PAT3: begin
                plen = pattern_span(run_kind);
                parse_pos = parse_pos + plen;
                run_left = (tag[4:0] + 8'd2) * plen[7:0] - 1'b1;
            end
            default: begin
                offset = {comp_mem[parse_pos], comp_mem[parse_pos + 1'b1]};
                if (offset == 16'd0) begin
                    stream_done = 1'b1;
                    run_left = '0;
                    res.at_end = 1'b1;
                    return res;
                end
                copy_pos = parse_pos + offset[ADDRESS_W-1:0];
                parse_pos = parse_pos + 2'd2;
                run_left = tag[5:0] + 8'd3;
            end
        endcase
        res.value = comp_mem[copy_pos];
        copy_pos = copy_pos + 1'b1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_pos = '0;
            copy_pos = '0;
            run_left = '0;
            run_kind = KIND_LIT0;
            stream_done = 1'b0;
            expected_bytes.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_end_seen = 0;
        end else begin
            if (i_strobe) begin
                if (expected_bytes.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result %02h end=%0b with no fetch pending", $time,
                             i_out_byte, i_stream_end);
                end else begin
                    want = expected_bytes.pop_front();
                    o_checked++;
                    if (want.at_end)
                        o_end_seen++;
                    if (i_out_byte !== want.value) begin
                        o_fail_count++;
                        $display("%0t: out_byte expected %02h, got %02h", $time,
                                 want.value, i_out_byte);
                    end
                    if (i_stream_end !== want.at_end) begin
                        o_fail_count++;
                        $display("%0t: stream_end expected %0b, got %0b", $time,
                                 want.at_end, i_stream_end);
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_opcode)
                    OP_WRITE: comp_mem[i_address] = i_data;
                    OP_START: begin
                        parse_pos = i_address;
                        copy_pos = i_address;
                        run_left = '0;
                        run_kind = KIND_LIT0;
                        stream_done = 1'b0;
                    end
                    OP_FETCH: expected_bytes.push_back(decode_fetch());
                    default: ;
                endcase
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

FILE: sim/tb_rle_backref_byte_decompressor.sv
module tb_rle_backref_byte_decompressor;
    import rlebr_pkg::*;

    localparam int REQUEST_GOAL = 1450;
    localparam int STALL_LIMIT  = 100;
    localparam logic [ADDRESS_W-1:0] ADDR_TOP = '1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_start = 1'b0;
    logic                 busy;
    logic [1:0]           opcode = OP_WRITE;
    logic [ADDRESS_W-1:0] address = '0;
    logic [DATA_W-1:0]    wdata = '0;
    logic                 strobe;
    logic [DATA_W-1:0]    out_byte;
    logic                 stream_end;

    int fail_count;
    int pending;
    int checked;
    int end_seen;

    bit                   stored [0:(1<<ADDRESS_W)-1];
    int                   kind_uses [8];
    int                   sent_items = 0;
    int                   fetches = 0;
    int                   streams = 0;
    int                   idle_cycles = 0;
    bit                   idle_ok = 1'b1;
    logic [ADDRESS_W-1:0] wr_pos;
    logic [ADDRESS_W-1:0] stream_base;

    rle_backref_byte_decompressor i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (req_start),
        .busy         (busy),
        .i_opcode     (opcode),
        .i_address    (address),
        .i_data       (wdata),
        .o_strobe     (strobe),
        .o_out_byte   (out_byte),
        .o_stream_end (stream_end)
    );

    rlebr_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (req_start),
        .i_busy       (busy),
        .i_opcode     (opcode),
        .i_address    (address),
        .i_data       (wdata),
        .i_strobe     (strobe),
        .i_out_byte   (out_byte),
        .i_stream_end (stream_end),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_end_seen   (end_seen)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n || (req_start && !busy) || strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic issue(input logic [1:0] op, input logic [ADDRESS_W-1:0] addr,
                         input logic [DATA_W-1:0] val);
        int gap;
        gap = (idle_ok && $urandom_range(99) < 16) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_start <= 1'b1;
        opcode <= op;
        address <= addr;
        wdata <= val;
        do @(posedge clk); while (busy !== 1'b0);
        if (op == OP_WRITE)
            stored[addr] = 1'b1;
        if (op == OP_FETCH)
            fetches++;
        if (op != OP_UNUSED)
            sent_items++;
    endtask

    task automatic emit(input logic [DATA_W-1:0] val);
        issue(OP_WRITE, wr_pos, val);
        wr_pos = wr_pos + 1'b1;
    endtask

    function automatic bit span_written(input logic [ADDRESS_W-1:0] src, input int cnt);
        logic [ADDRESS_W-1:0] a;
        int k;
        for (k = 0; k < cnt; k++) begin
            a = src + k;
            if (!stored[a])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int short_len();
        return ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(5);
    endfunction

    // ignored opcode, or a write that stays clear of the stream being fetched
    task automatic noise();
        logic [ADDRESS_W-1:0] a;
        logic [ADDRESS_W-1:0] rel_pos;
        logic [ADDRESS_W-1:0] span;
        span = wr_pos - stream_base;
        if ($urandom_range(1) == 0) begin
            issue(OP_UNUSED, $urandom, $urandom);
        end else begin
            do begin
                a = $urandom;
                rel_pos = a - stream_base;
            end while (rel_pos < span);
            issue(OP_WRITE, a, $urandom);
        end
    endtask

    task automatic fetch_some(input int n);
        repeat (n) begin
            if ($urandom_range(24) == 0)
                noise();
            issue(OP_FETCH, $urandom, $urandom);
        end
    endtask

    task automatic run_stream();
        logic [ADDRESS_W-1:0] src;
        logic [ADDRESS_W-1:0] p_off;
        logic [2:0]           kind;
        logic [DATA_W-1:0]    tag;
        logic [15:0]          off;
        int                   produced;
        int                   cnt;
        int                   plen;
        int                   tries;
        int                   mode;
        bit                   found;
        stream_base = ($urandom_range(5) == 0) ? 4096 - $urandom_range(1, 24) : $urandom;
        wr_pos = stream_base;
        produced = 0;
        repeat ($urandom_range(1, 5)) begin
            kind = $urandom_range(7);
            tag = {kind, 5'(short_len())};
            cnt = tag[5:0] + 4;
            if (kind >= KIND_REF0) begin
                p_off = wr_pos + 1'b1;
                found = 1'b0;
                for (tries = 0; tries < 16 && !found; tries++) begin
                    if ($urandom_range(3) == 0)
                        src = $urandom;
                    else
                        src = p_off + $urandom_range(400) - 200;
                    found = span_written(src, cnt);
                end
                // nothing usable to copy from yet
                if (!found) begin
                    kind = KIND_LIT0;
                    tag = {KIND_LIT0, tag[4:0]};
                end
            end
            kind_uses[kind]++;
            emit(tag);
            case (kind)
                KIND_LIT0, KIND_LIT1: begin
                    repeat (tag[5:0] + 1) emit($urandom);
                    produced += tag[5:0] + 1;
                end
                KIND_REPEAT: begin
                    emit($urandom);
                    produced += tag[4:0] + 3;
                end
                KIND_PAT4, KIND_PAT2, KIND_PAT3: begin
                    case (kind)
                        KIND_PAT4: plen = 4;
                        KIND_PAT2: plen = 2;
                        default:   plen = 3;
                    endcase
                    repeat (plen) emit($urandom);
                    produced += (tag[4:0] + 2) * plen;
                end
                default: begin
                    off[ADDRESS_W-1:0] = src - p_off;
                    off[15:ADDRESS_W] = $urandom;
                    if (off == 16'd0)
                        off[15:ADDRESS_W] = $urandom_range(1, 15);
                    emit(off[15:8]);
                    emit(off[7:0]);
                    produced += cnt;
                end
            endcase
        end
        // end marker: back-reference tag with zero offset
        emit({2'b11, 6'($urandom)});
        emit(8'h00);
        emit(8'h00);

        issue(OP_START, stream_base, $urandom);
        mode = $urandom_range(9);
        if (mode == 0) begin
            fetch_some($urandom_range(produced));
        end else begin
            if (mode == 1) begin
                fetch_some($urandom_range(produced));
                issue(OP_START, stream_base, $urandom);
            end
            fetch_some(produced + 1 + $urandom_range(2));
        end
        streams++;
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // hand-built stream at the top of the store, parsed from 0 with no start:
        // one literal, a repeat, a back-reference reaching across the wrap, end marker
        wr_pos = ADDR_TOP;
        stream_base = ADDR_TOP;
        emit(8'h5A);
        emit({KIND_LIT0, 5'd0});
        emit(8'hFF);
        emit({KIND_REPEAT, 5'd0});
        emit(8'h00);
        emit({KIND_REF0, 5'd0});
        emit(8'hFF);
        emit(8'hFA);
        emit({KIND_REF1, 5'h1F});
        emit(8'h00);
        emit(8'h00);
        issue(OP_UNUSED, ADDR_TOP, 8'hFF);
        fetch_some(10);

        while (sent_items < REQUEST_GOAL) begin
            idle_ok = !(streams >= 6 && streams < 12);
            run_stream();
        end
        @(negedge clk);
        req_start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (12) @(negedge clk);

        $display("%0d requests, %0d streams + 1 fixed, %0d fetches, %0d checked, %0d at end",
                 sent_items, streams, fetches, checked, end_seen);
        $display("runs: lit %0d/%0d rep %0d pat4/2/3 %0d/%0d/%0d ref %0d/%0d",
                 kind_uses[0], kind_uses[1], kind_uses[2], kind_uses[3], kind_uses[4],
                 kind_uses[5], kind_uses[6], kind_uses[7]);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: sim.f
src/rlebr_pkg.sv
src/rlebr_ctrl.sv
src/rlebr_dpath.sv
src/rle_backref_byte_decompressor.sv
sim/rlebr_checker.sv
sim/tb_rle_backref_byte_decompressor.sv
